@@ rtl/core/pfd_pkg.sv @@
// Shared types, constants and saturation helpers for the filtered-derivative PID core.
package pfd_pkg;

	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int SUM_W    = DATA_W + 3;
	localparam int A_W      = 64;
	localparam int B_W      = 34;
	localparam int P_W      = A_W + B_W;
	localparam int D_W      = 48;
	localparam int CNT_W    = 7;
	localparam int US_PER_S = 1000000;

	localparam logic signed [SUM_W-1:0] DATA_MAX = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] DATA_MIN = -DATA_MAX - SUM_W'(1);

	typedef enum logic [1:0] {
		REG_KP  = 2'd0,
		REG_KI  = 2'd1,
		REG_KD  = 2'd2,
		REG_TAU = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_P_MUL, S_P_DIV, S_P_ACC,
		S_F_MUL, S_F_DIV, S_F_ACC, S_K_MUL,
		S_KD_MUL, S_KD_DIV, S_KD_ACC, S_I_MUL1,
		S_I_MUL2, S_I_DIV, S_I_ACC, S_FIN
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] kp;
		logic [DATA_W-1:0] ki;
		logic [DATA_W-1:0] kd;
		logic [DATA_W-1:0] tau;
	} cfg_t;

	typedef struct packed {
		logic           go;
		op_t            op;
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
		logic [D_W-1:0] d;
	} arith_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_stat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     clip;
	} sat_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] drive;
		logic                     clip;
	} result_t;

	// Limit a quotient magnitude to the data range and apply the sign.
	function automatic sat_t sat_quot(input logic [P_W-1:0] q, input logic neg);
		logic [P_W-1:0]    lim;
		logic [DATA_W-1:0] m;
		sat_t              r;
		lim    = neg ? (P_W'(1) << (DATA_W - 1)) : ((P_W'(1) << (DATA_W - 1)) - P_W'(1));
		r.clip = q > lim;
		m      = r.clip ? lim[DATA_W-1:0] : q[DATA_W-1:0];
		r.val  = $signed(neg ? (~m + DATA_W'(1)) : m);
		return r;
	endfunction

	// Clamp a wide signed sum to the data range.
	function automatic sat_t sat_data(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if (v > DATA_MAX) begin
			r.clip = 1'b1;
			r.val  = DATA_MAX[DATA_W-1:0];
		end else if (v < DATA_MIN) begin
			r.clip = 1'b1;
			r.val  = DATA_MIN[DATA_W-1:0];
		end else begin
			r.clip = 1'b0;
			r.val  = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// Absolute value of a signed sum, widened to the multiplicand width.
	function automatic logic [A_W-1:0] mag(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-1:0] u;
		u = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
		return A_W'(u);
	endfunction

endpackage

@@ rtl/core/pid_filtered_derivative_core.sv @@
// Top level of the PID core with low-pass filtered derivative: registers, sequencer, unit, output.
// A PID step in signed Q16.16: drive = Kp*e + Kd*1e6*d/dt + integral, where d is the error change,
// low-passed by dt/(dt+tau) when tau is nonzero, and the integral grows by Ki*e*dt/1e6; terms,
// filter state, integral and sum saturate and raise clipped. All multiplies and divides run one
// bit per cycle on a single shift-add / restoring-divide unit. One item is in work at a time; the
// next beat is taken once the result has moved into the output register, which holds it until
// the receiver takes it.
module pid_filtered_derivative_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [1:0]                          cfg_index,
	input  logic [pfd_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pfd_pkg::DATA_W-1:0]   error_sample,
	input  logic [pfd_pkg::DATA_W-1:0]          dt_us,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pfd_pkg::DATA_W-1:0]   drive,
	output logic                                clipped
);

	pfd_pkg::cfg_t        cfg_q;
	pfd_pkg::arith_cmd_t  cmd;
	pfd_pkg::arith_stat_t stat;
	pfd_pkg::result_t     res;
	logic [pfd_pkg::P_W-1:0] p;
	logic                 res_ready;
	logic                 out_valid_q;
	logic signed [pfd_pkg::DATA_W-1:0] drive_q;
	logic                 clipped_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (pfd_pkg::reg_idx_t'(cfg_index))
				pfd_pkg::REG_KP:  cfg_q.kp  <= cfg_data;
				pfd_pkg::REG_KI:  cfg_q.ki  <= cfg_data;
				pfd_pkg::REG_KD:  cfg_q.kd  <= cfg_data;
				pfd_pkg::REG_TAU: cfg_q.tau <= cfg_data;
				default:          cfg_q     <= cfg_q;
			endcase
		end
	end

	pfd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.error_sample (error_sample),
		.dt_us        (dt_us),
		.res_ready    (res_ready),
		.res          (res),
		.cmd          (cmd),
		.stat         (stat),
		.p            (p)
	);

	pfd_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.p      (p)
	);

	// Output register: load a finished beat when the slot is free or draining
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			drive_q   <= res.drive;
			clipped_q <= res.clip;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clipped   = clipped_q;

endmodule

@@ rtl/core/pfd_arith.sv @@
// Shared bit-serial unit: shift-add multiplier and restoring divider on one product register.
module pfd_arith (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pfd_pkg::arith_cmd_t      cmd,
	output pfd_pkg::arith_stat_t     stat,
	output logic [pfd_pkg::P_W-1:0]  p
);

	logic [pfd_pkg::P_W-1:0]   p_q;
	logic [pfd_pkg::A_W-1:0]   a_q;
	logic [pfd_pkg::D_W-1:0]   d_q;
	logic [pfd_pkg::D_W-1:0]   rem_q;
	logic [pfd_pkg::CNT_W-1:0] cnt_q;
	pfd_pkg::op_t              op_q;

	logic [pfd_pkg::A_W:0]     mul_sum;
	logic [pfd_pkg::D_W:0]     div_t;
	logic [pfd_pkg::D_W:0]     div_diff;
	logic                      div_ge;

	// One multiplier bit: add the multiplicand into the high half, shift right
	assign mul_sum = {1'b0, p_q[pfd_pkg::P_W-1:pfd_pkg::B_W]}
		+ (p_q[0] ? {1'b0, a_q} : '0);

	// One quotient bit: bring in the next dividend bit, trial subtract
	assign div_t    = {rem_q, p_q[pfd_pkg::P_W-1]};
	assign div_diff = div_t - {1'b0, d_q};
	assign div_ge   = div_t >= {1'b0, d_q};

	assign stat.busy = cnt_q != '0;
	assign stat.done = cnt_q == pfd_pkg::CNT_W'(1);
	assign p         = p_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.go) begin
			cnt_q <= (cmd.op == pfd_pkg::OP_MUL) ? pfd_pkg::CNT_W'(pfd_pkg::B_W)
				: pfd_pkg::CNT_W'(pfd_pkg::P_W);
		end else if (stat.busy) begin
			cnt_q <= cnt_q - pfd_pkg::CNT_W'(1);
		end
	end

	// Operand load and shift datapath
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			a_q   <= cmd.a;
			d_q   <= cmd.d;
			op_q  <= cmd.op;
			rem_q <= '0;
			if (cmd.op == pfd_pkg::OP_MUL) begin
				p_q <= {{pfd_pkg::A_W{1'b0}}, cmd.b};
			end
		end else if (stat.busy) begin
			if (op_q == pfd_pkg::OP_MUL) begin
				p_q <= {mul_sum, p_q[pfd_pkg::B_W-1:1]};
			end else begin
				rem_q <= div_ge ? div_diff[pfd_pkg::D_W-1:0] : div_t[pfd_pkg::D_W-1:0];
				p_q   <= {p_q[pfd_pkg::P_W-2:0], div_ge};
			end
		end
	end

endmodule

@@ rtl/core/pfd_ctrl.sv @@
// Per-item sequencer: schedules the shared unit, accumulates terms, holds controller state.
module pfd_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pfd_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pfd_pkg::DATA_W-1:0]   error_sample,
	input  logic [pfd_pkg::DATA_W-1:0]          dt_us,
	input  logic                                res_ready,
	output pfd_pkg::result_t                    res,
	output pfd_pkg::arith_cmd_t                 cmd,
	input  pfd_pkg::arith_stat_t                stat,
	input  logic [pfd_pkg::P_W-1:0]             p
);

	pfd_pkg::state_t state_q, state_d;
	logic            launched_q;
	logic            is_op;

	logic signed [pfd_pkg::DATA_W-1:0] e_q;
	logic [pfd_pkg::DATA_W-1:0]        dt_q;
	logic signed [pfd_pkg::DATA_W-1:0] last_q;
	logic signed [pfd_pkg::DATA_W-1:0] integ_q;
	logic signed [pfd_pkg::DATA_W-1:0] filt_q;
	logic signed [pfd_pkg::SUM_W-1:0]  sum_q;
	logic signed [pfd_pkg::DATA_W:0]   dval_q;
	logic                              clip_q;

	logic signed [pfd_pkg::SUM_W-1:0] delta;
	logic signed [pfd_pkg::SUM_W-1:0] xdiff;
	logic [pfd_pkg::A_W-1:0]          mag_e, mag_kp, mag_ki, mag_kd, mag_x, mag_dv;
	logic [pfd_pkg::DATA_W-1:0]       dt_eff;
	logic                             kd_on, ki_on, tau_on;
	pfd_pkg::sat_t                    sq_p, sq_f, sq_d, sq_i, sat_f, sat_i, sat_sum;

	assign kd_on  = cfg.kd != '0;
	assign ki_on  = cfg.ki != '0;
	assign tau_on = cfg.tau != '0;
	assign dt_eff = (dt_q == '0) ? pfd_pkg::DATA_W'(1) : dt_q;

	// Error change and filter residual
	assign delta = pfd_pkg::SUM_W'(e_q) - pfd_pkg::SUM_W'(last_q);
	assign xdiff = delta - pfd_pkg::SUM_W'(filt_q);

	assign mag_e  = pfd_pkg::mag(pfd_pkg::SUM_W'(e_q));
	assign mag_kp = pfd_pkg::mag(pfd_pkg::SUM_W'($signed(cfg.kp)));
	assign mag_ki = pfd_pkg::mag(pfd_pkg::SUM_W'($signed(cfg.ki)));
	assign mag_kd = pfd_pkg::mag(pfd_pkg::SUM_W'($signed(cfg.kd)));
	assign mag_x  = pfd_pkg::mag(xdiff);
	assign mag_dv = pfd_pkg::mag(pfd_pkg::SUM_W'(dval_q));

	// Term saturation on the finished quotient
	assign sq_p    = pfd_pkg::sat_quot(p, cfg.kp[pfd_pkg::DATA_W-1] ^ e_q[pfd_pkg::DATA_W-1]);
	assign sq_f    = pfd_pkg::sat_quot(p, xdiff[pfd_pkg::SUM_W-1]);
	assign sq_d    = pfd_pkg::sat_quot(p, cfg.kd[pfd_pkg::DATA_W-1] ^ dval_q[pfd_pkg::DATA_W]);
	assign sq_i    = pfd_pkg::sat_quot(p, cfg.ki[pfd_pkg::DATA_W-1] ^ e_q[pfd_pkg::DATA_W-1]);
	assign sat_f   = pfd_pkg::sat_data(pfd_pkg::SUM_W'(filt_q) + pfd_pkg::SUM_W'(sq_f.val));
	assign sat_i   = pfd_pkg::sat_data(pfd_pkg::SUM_W'(integ_q) + pfd_pkg::SUM_W'(sq_i.val));
	assign sat_sum = pfd_pkg::sat_data(sum_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfd_pkg::S_IDLE:   if (in_valid) state_d = pfd_pkg::S_P_MUL;
			pfd_pkg::S_P_MUL:  if (stat.done) state_d = pfd_pkg::S_P_DIV;
			pfd_pkg::S_P_DIV:  if (stat.done) state_d = pfd_pkg::S_P_ACC;
			pfd_pkg::S_P_ACC: begin
				if (kd_on) begin
					state_d = tau_on ? pfd_pkg::S_F_MUL : pfd_pkg::S_K_MUL;
				end else begin
					state_d = ki_on ? pfd_pkg::S_I_MUL1 : pfd_pkg::S_FIN;
				end
			end
			pfd_pkg::S_F_MUL:  if (stat.done) state_d = pfd_pkg::S_F_DIV;
			pfd_pkg::S_F_DIV:  if (stat.done) state_d = pfd_pkg::S_F_ACC;
			pfd_pkg::S_F_ACC:  state_d = pfd_pkg::S_K_MUL;
			pfd_pkg::S_K_MUL:  if (stat.done) state_d = pfd_pkg::S_KD_MUL;
			pfd_pkg::S_KD_MUL: if (stat.done) state_d = pfd_pkg::S_KD_DIV;
			pfd_pkg::S_KD_DIV: if (stat.done) state_d = pfd_pkg::S_KD_ACC;
			pfd_pkg::S_KD_ACC: state_d = ki_on ? pfd_pkg::S_I_MUL1 : pfd_pkg::S_FIN;
			pfd_pkg::S_I_MUL1: if (stat.done) state_d = pfd_pkg::S_I_MUL2;
			pfd_pkg::S_I_MUL2: if (stat.done) state_d = pfd_pkg::S_I_DIV;
			pfd_pkg::S_I_DIV:  if (stat.done) state_d = pfd_pkg::S_I_ACC;
			pfd_pkg::S_I_ACC:  state_d = pfd_pkg::S_FIN;
			pfd_pkg::S_FIN:    if (res_ready) state_d = pfd_pkg::S_IDLE;
			default:           state_d = pfd_pkg::S_IDLE;
		endcase
	end

	// Outputs: unit commands, handshake, result
	always_comb begin
		is_op = state_q inside {pfd_pkg::S_P_MUL, pfd_pkg::S_P_DIV, pfd_pkg::S_F_MUL,
			pfd_pkg::S_F_DIV, pfd_pkg::S_K_MUL, pfd_pkg::S_KD_MUL, pfd_pkg::S_KD_DIV,
			pfd_pkg::S_I_MUL1, pfd_pkg::S_I_MUL2, pfd_pkg::S_I_DIV};
		cmd.go = is_op && !launched_q;
		cmd.op = pfd_pkg::OP_MUL;
		cmd.a  = '0;
		cmd.b  = '0;
		cmd.d  = pfd_pkg::D_W'(1);
		case (state_q)
			pfd_pkg::S_P_MUL: begin
				cmd.a = mag_kp;
				cmd.b = mag_e[pfd_pkg::B_W-1:0];
			end
			pfd_pkg::S_P_DIV: begin
				cmd.op = pfd_pkg::OP_DIV;
				cmd.d  = pfd_pkg::D_W'(1) << pfd_pkg::FRAC_W;
			end
			pfd_pkg::S_F_MUL: begin
				cmd.a = mag_x;
				cmd.b = pfd_pkg::B_W'(dt_q);
			end
			pfd_pkg::S_F_DIV: begin
				cmd.op = pfd_pkg::OP_DIV;
				cmd.d  = pfd_pkg::D_W'(dt_q) + pfd_pkg::D_W'(cfg.tau);
			end
			pfd_pkg::S_K_MUL: begin
				cmd.a = mag_kd;
				cmd.b = pfd_pkg::B_W'(pfd_pkg::US_PER_S);
			end
			pfd_pkg::S_KD_MUL: begin
				cmd.a = p[pfd_pkg::A_W-1:0];
				cmd.b = mag_dv[pfd_pkg::B_W-1:0];
			end
			pfd_pkg::S_KD_DIV: begin
				cmd.op = pfd_pkg::OP_DIV;
				cmd.d  = pfd_pkg::D_W'(dt_eff) << pfd_pkg::FRAC_W;
			end
			pfd_pkg::S_I_MUL1: begin
				cmd.a = mag_ki;
				cmd.b = pfd_pkg::B_W'(dt_q);
			end
			pfd_pkg::S_I_MUL2: begin
				cmd.a = p[pfd_pkg::A_W-1:0];
				cmd.b = mag_e[pfd_pkg::B_W-1:0];
			end
			pfd_pkg::S_I_DIV: begin
				cmd.op = pfd_pkg::OP_DIV;
				cmd.d  = pfd_pkg::D_W'(pfd_pkg::US_PER_S) << pfd_pkg::FRAC_W;
			end
			default: begin
				cmd.op = pfd_pkg::OP_MUL;
			end
		endcase
		in_stall  = state_q != pfd_pkg::S_IDLE;
		res.valid = state_q == pfd_pkg::S_FIN;
		res.drive = sat_sum.val;
		res.clip  = clip_q | sat_sum.clip;
	end

	// State, launch flag and controller memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pfd_pkg::S_IDLE;
			launched_q <= 1'b0;
			last_q     <= '0;
			integ_q    <= '0;
			filt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.go) begin
				launched_q <= 1'b1;
			end else if (stat.done) begin
				launched_q <= 1'b0;
			end
			if (state_q == pfd_pkg::S_F_ACC) begin
				filt_q <= sat_f.val;
			end
			if (state_q == pfd_pkg::S_I_ACC) begin
				integ_q <= sat_i.val;
			end
			if (state_q == pfd_pkg::S_FIN && res_ready) begin
				last_q <= e_q;
			end
		end
	end

	// Item capture and term accumulation
	always_ff @(posedge clk) begin
		case (state_q)
			pfd_pkg::S_IDLE: begin
				e_q    <= error_sample;
				dt_q   <= dt_us;
				clip_q <= 1'b0;
			end
			pfd_pkg::S_P_ACC: begin
				sum_q  <= pfd_pkg::SUM_W'(sq_p.val);
				clip_q <= clip_q | sq_p.clip;
				dval_q <= delta[pfd_pkg::DATA_W:0];
			end
			pfd_pkg::S_F_ACC: begin
				clip_q <= clip_q | sat_f.clip;
				dval_q <= (pfd_pkg::DATA_W + 1)'(sat_f.val);
			end
			pfd_pkg::S_KD_ACC: begin
				sum_q  <= sum_q + pfd_pkg::SUM_W'(sq_d.val);
				clip_q <= clip_q | sq_d.clip;
			end
			pfd_pkg::S_I_ACC: begin
				sum_q  <= sum_q + pfd_pkg::SUM_W'(sat_i.val);
				clip_q <= clip_q | sq_i.clip | sat_i.clip;
			end
			default: begin
				clip_q <= clip_q;
			end
		endcase
	end

	// Unit is only launched when free
	a_go_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !stat.busy) else $error("unit launched while busy");

	// Unit is quiet whenever no item is in work
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfd_pkg::S_IDLE |-> !stat.busy) else $error("unit busy in idle");

	// A finishing operation was launched by this sequencer
	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> launched_q) else $error("unit finished an unlaunched operation");

endmodule

@@ tb/pid_filtered_derivative_core_tb.sv @@
// Self-checking testbench for the filtered-derivative PID core: predictor scoreboard and stimulus.
class pid_drive_board;
	logic signed [31:0] kp, ki, kd;
	logic [31:0]        tau;
	longint             last_err, integ, filt;
	bit                 clip_hit;
	logic [31:0]        drive_q[$];
	bit                 clip_q[$];
	int                 fails;

	function new();
		kp = 0; ki = 0; kd = 0; tau = 0;
		last_err = 0; integ = 0; filt = 0;
		fails = 0;
	endfunction

	function void set_reg(pfd_pkg::reg_idx_t idx, logic [31:0] v);
		case (idx)
			pfd_pkg::REG_KP:  kp = v;
			pfd_pkg::REG_KI:  ki = v;
			pfd_pkg::REG_KD:  kd = v;
			pfd_pkg::REG_TAU: tau = v;
			default:          ;
		endcase
	endfunction

	// Clamp to the signed 32-bit range and flag it.
	function longint sat32(longint v);
		if (v > 64'sd2147483647) begin
			clip_hit = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip_hit = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Exact a*b/den truncated toward zero, saturated to the data range.
	function longint mul_div(longint a, longint b, logic [63:0] den);
		bit           neg;
		logic [63:0]  ma, mb, lim;
		logic [127:0] q;
		neg = (a < 0) != (b < 0);
		ma  = a < 0 ? -a : a;
		mb  = b < 0 ? -b : b;
		lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
		q   = ({64'd0, ma} * {64'd0, mb}) / {64'd0, (den == 0 ? 64'd1 : den)};
		if (q > {64'd0, lim}) begin
			q = {64'd0, lim};
			clip_hit = 1;
		end
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// Advance the controller state for one accepted beat and queue its result.
	function void note_input(logic signed [31:0] err, logic [31:0] dt);
		longint e, sum, d, stp, inc;
		bit     saved;
		clip_hit = 0;
		e   = err;
		sum = mul_div(kp, e, 64'd65536);
		if (kd != 0) begin
			d = e - last_err;
			if (tau != 0) begin
				saved    = clip_hit;
				stp      = mul_div(d - filt, longint'({32'd0, dt}), {32'd0, dt} + {32'd0, tau});
				clip_hit = saved;
				filt     = sat32(filt + stp);
				d        = filt;
			end
			sum += mul_div(longint'(kd) * 1000000, d, {16'd0, (dt == 0 ? 32'd1 : dt), 16'd0});
		end
		if (ki != 0) begin
			inc   = mul_div(longint'(ki) * longint'({32'd0, dt}), e, 64'd1000000 << 16);
			integ = sat32(integ + inc);
			sum  += integ;
		end
		sum      = sat32(sum);
		last_err = e;
		drive_q.push_back(sum[31:0]);
		clip_q.push_back(clip_hit);
	endfunction

	function void check_result(logic [31:0] drv, logic clp);
		logic [31:0] exp_drv;
		bit          exp_clp;
		if (drive_q.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected result drive=%h clipped=%b", drv, clp);
			return;
		end
		exp_drv = drive_q.pop_front();
		exp_clp = clip_q.pop_front();
		if (drv !== exp_drv || clp !== exp_clp) begin
			fails++;
			if (fails <= 10)
				$display("mismatch: drive exp %h got %h, clipped exp %b got %b",
					exp_drv, drv, exp_clp, clp);
		end
	endfunction

	function int pending();
		return drive_q.size();
	endfunction
endclass

module pid_filtered_derivative_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 8000;

	logic               clk, arst_n;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid, in_stall;
	logic signed [31:0] error_sample;
	logic [31:0]        dt_us;
	logic               out_valid, out_stall;
	logic signed [31:0] drive;
	logic               clipped;

	pid_drive_board board = new();
	bit             idle_on = 1;
	int             quiet_cycles = 0;

	pid_filtered_derivative_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.error_sample(error_sample), .dt_us(dt_us),
		.out_valid(out_valid), .out_stall(out_stall),
		.drive(drive), .clipped(clipped)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Stall the result side at random.
	always @(posedge clk)
		out_stall <= idle_on && ($urandom_range(99) < 16);

	// Check each accepted result beat; watch for a hang.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(drive, clipped);
		if ((out_valid && !out_stall) || (in_valid && !in_stall) || !arst_n || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Present one beat, idling first at random, and hold it until accepted.
	task automatic send_item(logic [31:0] e, logic [31:0] dt);
		while (idle_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		error_sample <= e;
		dt_us        <= dt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_input(e, dt);
	endtask

	// Drop valid, wait out every result, then load all four registers.
	task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] t);
		logic [31:0] vals[4];
		vals = '{p, i, d, t};
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		for (int k = 0; k < 4; k++) begin
			cfg_write <= 1'b1;
			cfg_index <= pfd_pkg::reg_idx_t'(k);
			cfg_data  <= vals[k];
			board.set_reg(pfd_pkg::reg_idx_t'(k), vals[k]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(4))
			0:       return 32'd0;
			1:       return $urandom;
			default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
		endcase
	endfunction

	function automatic logic [31:0] rand_error();
		if ($urandom_range(9) < 2)
			return $urandom;
		return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
	endfunction

	function automatic logic [31:0] rand_dt();
		logic [31:0] v;
		if ($urandom_range(9) == 0) begin
			v = $urandom;
			return v == 0 ? 32'd1 : v;
		end
		return $urandom_range(1, 20000);
	endfunction

	initial begin
		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= pfd_pkg::REG_KP;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		error_sample <= '0;
		dt_us        <= 32'd1;
		out_stall    <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all gains zero after reset.
		send_item(32'h7fff_ffff, 32'd1000);
		send_item(32'h8000_0000, 32'hffff_ffff);

		// Extreme gains and the slowest filter.
		set_gains(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		send_item(32'h7fff_ffff, 32'hffff_ffff);
		send_item(32'h8000_0000, 32'd1);
		send_item(32'h0000_0001, 32'd0);
		set_gains(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
		send_item(32'h8000_0000, 32'd1);
		send_item(32'h7fff_ffff, 32'hffff_ffff);
		send_item(32'hffff_ffff, 32'd0);

		// Moderate gains: filter on, then derivative off with filter set.
		set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0290, 32'd1000);
		send_item(32'h0000_0000, 32'd1000);
		send_item(32'h0001_0000, 32'd1000);
		send_item(32'hffff_0000, 32'd500);
		send_item(32'h0000_0000, 32'd0);
		send_item(32'hffff_ffff, 32'd1);
		set_gains(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'd5000);
		send_item(32'h0000_4000, 32'd100);
		send_item(32'hffff_c000, 32'd100);
		set_gains(32'h0000_0000, 32'h0001_0000, 32'h0000_1000, 32'd1);
		send_item(32'h0010_0000, 32'd20000);
		send_item(32'hfff0_0000, 32'd1);
		send_item(32'h0000_0000, 32'hffff_ffff);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 11; ph++) begin
			set_gains(rand_gain(), rand_gain(), rand_gain(),
				$urandom_range(1) ? 32'd0 :
				($urandom_range(7) == 0 ? $urandom : $urandom_range(1, 50000)));
			idle_on = (ph != 4);
			for (int n = 0; n < 100; n++)
				send_item(rand_error(), rand_dt());
		end
		idle_on = 1;

		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
		if (board.fails == 0 && board.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
